FILE: hw/rtl/htd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Huffman tree build and decode: shared package
// Field widths, operation and status codes, sequencer states and the
// memory control bundle used between the controller and the node store.
// ----------------------------------------------------------------------------
package htd_pkg;

  localparam int MAX_SYMBOLS_DEF = 128;

  localparam int OP_W        = 2;
  localparam int SYM_W       = 8;
  localparam int WEIGHT_IN_W = 24;
  localparam int WEIGHT_W    = 32;
  localparam int STATUS_W    = 2;
  localparam int CFG_W       = 8;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR  = 2'd0,
    OP_LOAD   = 2'd1,
    OP_DECODE = 2'd2
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_BUILT = 2'd1,
    ST_NO_BRANCH = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD_A,
    S_RD_B,
    S_SUM,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_PLACE,
    S_DEC_CHK,
    S_DEC_SYM,
    S_OUT
  } state_e;

  typedef struct packed {
    logic wl_we;
    logic wl_re;
    logic node_we;
    logic node_re;
    logic sym_we;
    logic sym_re;
  } mem_ctl_t;

endpackage

FILE: hw/rtl/htd_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Huffman tree build and decode: channel interfaces
// Input item, result item and configuration write channels, each with
// valid/ready and a source and a sink modport.
// ----------------------------------------------------------------------------
interface htd_in_if;
  logic                            valid;
  logic                            ready;
  logic [htd_pkg::OP_W-1:0]        op;
  logic [htd_pkg::SYM_W-1:0]       leaf_symbol;
  logic [htd_pkg::WEIGHT_IN_W-1:0] leaf_weight;
  logic                            code_bit;

  modport source (output valid, op, leaf_symbol, leaf_weight, code_bit, input ready);
  modport sink   (input valid, op, leaf_symbol, leaf_weight, code_bit, output ready);
endinterface

interface htd_out_if;
  logic                         valid;
  logic                         ready;
  logic [htd_pkg::SYM_W-1:0]    decoded_symbol;
  logic [htd_pkg::STATUS_W-1:0] status;

  modport source (output valid, decoded_symbol, status, input ready);
  modport sink   (input valid, decoded_symbol, status, output ready);
endinterface

interface htd_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [htd_pkg::CFG_W-1:0] symbol_count;

  modport source (output valid, symbol_count, input ready);
  modport sink   (input valid, symbol_count, output ready);
endinterface

FILE: hw/rtl/htd_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Huffman tree build and decode: node store
// Work list (node index plus weight), child pointer table and leaf symbol
// table. One write and one registered read per memory per cycle.
// ----------------------------------------------------------------------------
module htd_store #(
  parameter int MAX_SYMBOLS = htd_pkg::MAX_SYMBOLS_DEF
) (
  input  logic                    clk_i,
  input  htd_pkg::mem_ctl_t       ctl_i,
  input  logic [LW-1:0]           wl_waddr_i,
  input  logic [LW-1:0]           wl_raddr_i,
  input  logic [EW-1:0]           wl_wdata_i,
  output logic [EW-1:0]           wl_rdata_o,
  input  logic [IW-1:0]           node_waddr_i,
  input  logic [IW-1:0]           node_raddr_i,
  input  logic [NW-1:0]           node_wdata_i,
  output logic [NW-1:0]           node_rdata_o,
  input  logic [LW-1:0]           sym_waddr_i,
  input  logic [LW-1:0]           sym_raddr_i,
  input  logic [htd_pkg::SYM_W-1:0] sym_wdata_i,
  output logic [htd_pkg::SYM_W-1:0] sym_rdata_o
);

  localparam int IW = $clog2(2 * MAX_SYMBOLS);
  localparam int LW = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;
  localparam int EW = IW + htd_pkg::WEIGHT_W;
  localparam int NW = 2 * IW + 1;
  localparam int NODE_SLOTS = 2 * MAX_SYMBOLS;

  logic [EW-1:0]             wl_mem   [MAX_SYMBOLS];
  logic [NW-1:0]             node_mem [NODE_SLOTS];
  logic [htd_pkg::SYM_W-1:0] sym_mem  [MAX_SYMBOLS];

  always_ff @(posedge clk_i) begin
    if (ctl_i.wl_we) begin
      wl_mem[wl_waddr_i] <= wl_wdata_i;
    end
    if (ctl_i.wl_re) begin
      wl_rdata_o <= wl_mem[wl_raddr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.node_we) begin
      node_mem[node_waddr_i] <= node_wdata_i;
    end
    if (ctl_i.node_re) begin
      node_rdata_o <= node_mem[node_raddr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.sym_we) begin
      sym_mem[sym_waddr_i] <= sym_wdata_i;
    end
    if (ctl_i.sym_re) begin
      sym_rdata_o <= sym_mem[sym_raddr_i];
    end
  end

endmodule

FILE: hw/rtl/htd_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Huffman tree build and decode: sequencer
// Loads leaves, runs the join/insert build over the work list with one
// shared adder and comparator, walks the tree one bit per decode item and
// holds the result register.
// ----------------------------------------------------------------------------
module htd_ctrl #(
  parameter int MAX_SYMBOLS = htd_pkg::MAX_SYMBOLS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  htd_in_if.sink                    in_i,
  htd_out_if.source                 out_o,
  htd_cfg_if.sink                   cfg_i,
  output htd_pkg::mem_ctl_t         ctl_o,
  output logic [LW-1:0]             wl_waddr_o,
  output logic [LW-1:0]             wl_raddr_o,
  output logic [EW-1:0]             wl_wdata_o,
  input  logic [EW-1:0]             wl_rdata_i,
  output logic [IW-1:0]             node_waddr_o,
  output logic [IW-1:0]             node_raddr_o,
  output logic [NW-1:0]             node_wdata_o,
  input  logic [NW-1:0]             node_rdata_i,
  output logic [LW-1:0]             sym_waddr_o,
  output logic [LW-1:0]             sym_raddr_o,
  output logic [htd_pkg::SYM_W-1:0] sym_wdata_o,
  input  logic [htd_pkg::SYM_W-1:0] sym_rdata_i
);

  localparam int IW = $clog2(2 * MAX_SYMBOLS);
  localparam int LW = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;
  localparam int CW = $clog2(MAX_SYMBOLS + 1);
  localparam int WW = htd_pkg::WEIGHT_W;
  localparam int EW = IW + WW;
  localparam int NW = 2 * IW + 1;
  localparam logic [8:0] MAX9 = 9'(MAX_SYMBOLS);

  htd_pkg::state_e state_q, state_d;

  logic [htd_pkg::CFG_W-1:0] sc_q, sc_d;
  logic [CW-1:0]             leaves_q, leaves_d;
  logic [CW-1:0]             i_q, i_d;
  logic [CW-1:0]             j_q, j_d;
  logic                      tree_q, tree_d;
  logic [IW-1:0]             root_q, root_d;
  logic [IW-1:0]             walk_q, walk_d;
  logic [IW-1:0]             node_q, node_d;
  logic [EW-1:0]             a_q, a_d;
  logic [WW-1:0]             wsum_q, wsum_d;
  logic                      bit_q, bit_d;
  logic [htd_pkg::SYM_W-1:0] res_sym_q, res_sym_d;
  htd_pkg::status_e          res_st_q, res_st_d;
  logic                      out_valid_q, out_valid_d;
  logic [htd_pkg::SYM_W-1:0] out_sym_q, out_sym_d;
  htd_pkg::status_e          out_st_q, out_st_d;

  logic          in_fire;
  logic          out_free;
  logic [8:0]    sc_ext;
  logic [CW-1:0] target;
  logic [CW-1:0] n_next;
  logic          load_ok;
  logic          build_go;
  logic          single;
  logic [CW-1:0] i_next;
  logic [CW-1:0] i_prev;
  logic [CW-1:0] j_prev;
  logic          i_more;
  logic          j_lt_n;
  logic [IW-1:0] a_idx;
  logic [WW-1:0] a_w;
  logic [WW-1:0] rd_w;
  logic [WW-1:0] sum;
  logic          less;
  logic [IW-1:0] left_c;
  logic [IW:0]   right_c;
  logic [IW-1:0] child;
  logic          missing;
  logic          child_leaf;

  assign in_fire  = in_i.valid & in_i.ready;
  assign out_free = ~out_valid_q | out_o.ready;

  // clamp the configured count to 1..MAX_SYMBOLS
  always_comb begin
    sc_ext = {1'b0, sc_q};
    if (sc_q == '0) begin
      target = CW'(1);
    end else if (sc_ext > MAX9) begin
      target = CW'(MAX_SYMBOLS);
    end else begin
      target = CW'(sc_ext);
    end
  end

  assign n_next   = leaves_q + CW'(1);
  assign load_ok  = ~tree_q & (leaves_q < CW'(MAX_SYMBOLS));
  assign build_go = (n_next >= target);
  assign single   = (n_next == CW'(1));
  assign i_next   = i_q + CW'(1);
  assign i_prev   = i_q - CW'(1);
  assign j_prev   = j_q - CW'(1);
  assign i_more   = (i_next < leaves_q);
  assign j_lt_n   = (j_q < leaves_q);

  // shared adder and comparator
  assign a_idx = a_q[EW-1:WW];
  assign a_w   = a_q[WW-1:0];
  assign rd_w  = wl_rdata_i[WW-1:0];
  assign sum   = a_w + rd_w;
  assign less  = (wsum_q < rd_w);

  // right pointer carries a missing-branch flag in its top bit
  assign left_c     = node_rdata_i[NW-1:IW+1];
  assign right_c    = node_rdata_i[IW:0];
  assign missing    = bit_q & right_c[IW];
  assign child      = bit_q ? right_c[IW-1:0] : left_c;
  assign child_leaf = (child < IW'(leaves_q));

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      htd_pkg::S_IDLE: begin
        if (in_fire) begin
          priority case (in_i.op)
            htd_pkg::OP_LOAD: begin
              if (load_ok && build_go && !single) begin
                state_d = htd_pkg::S_RD_A;
              end
            end
            htd_pkg::OP_DECODE: begin
              state_d = tree_q ? htd_pkg::S_DEC_CHK : htd_pkg::S_OUT;
            end
            default: state_d = htd_pkg::S_IDLE;
          endcase
        end
      end
      htd_pkg::S_RD_A:     state_d = htd_pkg::S_RD_B;
      htd_pkg::S_RD_B:     state_d = htd_pkg::S_SUM;
      htd_pkg::S_SUM:      state_d = htd_pkg::S_SCAN_RD;
      htd_pkg::S_SCAN_RD: begin
        state_d = j_lt_n ? htd_pkg::S_SCAN_CMP : htd_pkg::S_PLACE;
      end
      htd_pkg::S_SCAN_CMP: begin
        state_d = less ? htd_pkg::S_PLACE : htd_pkg::S_SCAN_RD;
      end
      htd_pkg::S_PLACE: begin
        state_d = i_more ? htd_pkg::S_RD_A : htd_pkg::S_IDLE;
      end
      htd_pkg::S_DEC_CHK: begin
        if (missing) begin
          state_d = htd_pkg::S_OUT;
        end else if (child_leaf) begin
          state_d = htd_pkg::S_DEC_SYM;
        end else begin
          state_d = htd_pkg::S_IDLE;
        end
      end
      htd_pkg::S_DEC_SYM:  state_d = htd_pkg::S_OUT;
      htd_pkg::S_OUT: begin
        if (out_free) begin
          state_d = htd_pkg::S_IDLE;
        end
      end
      default: state_d = htd_pkg::S_IDLE;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    sc_d        = sc_q;
    leaves_d    = leaves_q;
    i_d         = i_q;
    j_d         = j_q;
    tree_d      = tree_q;
    root_d      = root_q;
    walk_d      = walk_q;
    node_d      = node_q;
    a_d         = a_q;
    wsum_d      = wsum_q;
    bit_d       = bit_q;
    res_sym_d   = res_sym_q;
    res_st_d    = res_st_q;
    out_valid_d = out_valid_q;
    out_sym_d   = out_sym_q;
    out_st_d    = out_st_q;

    ctl_o        = '0;
    wl_waddr_o   = '0;
    wl_raddr_o   = '0;
    wl_wdata_o   = '0;
    node_waddr_o = '0;
    node_raddr_o = '0;
    node_wdata_o = '0;
    sym_waddr_o  = '0;
    sym_raddr_o  = '0;
    sym_wdata_o  = '0;

    if (cfg_i.valid) begin
      sc_d = cfg_i.symbol_count;
    end
    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      htd_pkg::S_IDLE: begin
        if (in_fire) begin
          priority case (in_i.op)
            htd_pkg::OP_CLEAR: begin
              leaves_d = '0;
              tree_d   = 1'b0;
              root_d   = '0;
              walk_d   = '0;
            end
            htd_pkg::OP_LOAD: begin
              if (load_ok) begin
                ctl_o.wl_we  = 1'b1;
                wl_waddr_o   = leaves_q[LW-1:0];
                wl_wdata_o   = {IW'(leaves_q), WW'(in_i.leaf_weight)};
                ctl_o.sym_we = 1'b1;
                sym_waddr_o  = leaves_q[LW-1:0];
                sym_wdata_o  = in_i.leaf_symbol;
                leaves_d     = n_next;
                if (build_go) begin
                  if (single) begin
                    // lone leaf: root in slot 1, left is the leaf, no right
                    ctl_o.node_we = 1'b1;
                    node_waddr_o  = IW'(1);
                    node_wdata_o  = {IW'(0), 1'b1, IW'(0)};
                    root_d        = IW'(1);
                    walk_d        = IW'(1);
                    tree_d        = 1'b1;
                  end else begin
                    i_d    = CW'(1);
                    node_d = IW'(n_next);
                  end
                end
              end
            end
            htd_pkg::OP_DECODE: begin
              if (tree_q) begin
                ctl_o.node_re = 1'b1;
                node_raddr_o  = walk_q;
                bit_d         = in_i.code_bit;
              end else begin
                res_sym_d = '0;
                res_st_d  = htd_pkg::ST_NOT_BUILT;
              end
            end
            default: ;
          endcase
        end
      end
      htd_pkg::S_RD_A: begin
        ctl_o.wl_re = 1'b1;
        wl_raddr_o  = i_prev[LW-1:0];
      end
      htd_pkg::S_RD_B: begin
        a_d         = wl_rdata_i;
        ctl_o.wl_re = 1'b1;
        wl_raddr_o  = i_q[LW-1:0];
      end
      htd_pkg::S_SUM: begin
        wsum_d        = sum;
        ctl_o.node_we = 1'b1;
        node_waddr_o  = node_q;
        node_wdata_o  = {a_idx, 1'b0, wl_rdata_i[EW-1:WW]};
        j_d           = i_next;
      end
      htd_pkg::S_SCAN_RD: begin
        if (j_lt_n) begin
          ctl_o.wl_re = 1'b1;
          wl_raddr_o  = j_q[LW-1:0];
        end
      end
      htd_pkg::S_SCAN_CMP: begin
        // equal weights move ahead of the new node
        if (!less) begin
          ctl_o.wl_we = 1'b1;
          wl_waddr_o  = j_prev[LW-1:0];
          wl_wdata_o  = wl_rdata_i;
          j_d         = j_q + CW'(1);
        end
      end
      htd_pkg::S_PLACE: begin
        ctl_o.wl_we = 1'b1;
        wl_waddr_o  = j_prev[LW-1:0];
        wl_wdata_o  = {node_q, wsum_q};
        node_d      = node_q + IW'(1);
        if (i_more) begin
          i_d = i_next;
        end else begin
          root_d = node_q;
          walk_d = node_q;
          tree_d = 1'b1;
        end
      end
      htd_pkg::S_DEC_CHK: begin
        if (missing) begin
          walk_d    = root_q;
          res_sym_d = '0;
          res_st_d  = htd_pkg::ST_NO_BRANCH;
        end else if (child_leaf) begin
          ctl_o.sym_re = 1'b1;
          sym_raddr_o  = child[LW-1:0];
          walk_d       = root_q;
        end else begin
          walk_d = child;
        end
      end
      htd_pkg::S_DEC_SYM: begin
        res_sym_d = sym_rdata_i;
        res_st_d  = htd_pkg::ST_OK;
      end
      htd_pkg::S_OUT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_sym_d   = res_sym_q;
          out_st_d    = res_st_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= htd_pkg::S_IDLE;
      sc_q        <= htd_pkg::CFG_W'(1);
      leaves_q    <= '0;
      i_q         <= '0;
      j_q         <= '0;
      tree_q      <= 1'b0;
      root_q      <= '0;
      walk_q      <= '0;
      node_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sc_q        <= sc_d;
      leaves_q    <= leaves_d;
      i_q         <= i_d;
      j_q         <= j_d;
      tree_q      <= tree_d;
      root_q      <= root_d;
      walk_q      <= walk_d;
      node_q      <= node_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q       <= a_d;
    wsum_q    <= wsum_d;
    bit_q     <= bit_d;
    res_sym_q <= res_sym_d;
    res_st_q  <= res_st_d;
    out_sym_q <= out_sym_d;
    out_st_q  <= out_st_d;
  end

  assign in_i.ready           = (state_q == htd_pkg::S_IDLE);
  assign cfg_i.ready          = 1'b1;
  assign out_o.valid          = out_valid_q;
  assign out_o.decoded_symbol = out_sym_q;
  assign out_o.status         = out_st_q;

`ifndef SYNTHESIS
  a_leaves_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    leaves_q <= CW'(MAX_SYMBOLS))
    else $error("leaf count beyond table depth");

  a_walk_internal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tree_q |-> (walk_q >= IW'(leaves_q)))
    else $error("walk position sits on a leaf");

  a_build_root: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(tree_q) |-> (walk_q == root_q))
    else $error("walk not at root after build");

  a_scan_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == htd_pkg::S_SCAN_RD || state_q == htd_pkg::S_SCAN_CMP) |->
      (j_q <= leaves_q && i_q < leaves_q && j_q > i_q))
    else $error("insert scan pointer out of range");

  a_not_built: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && in_i.op == htd_pkg::OP_DECODE && !tree_q) |=>
      (state_q == htd_pkg::S_OUT && res_st_q == htd_pkg::ST_NOT_BUILT))
    else $error("decode before build did not flag");
`endif

endmodule

FILE: hw/rtl/huffman_tree_build_and_decode_unit.sv
`timescale 1ns / 1ps
// Clear and load finish in the idle state; a decode bit reads the child table and is
//   checked in S_DEC_CHK, a leaf fetching its symbol in S_DEC_SYM; a leaf or an error
//   then loads the output register in S_OUT. A new bit is taken only back in idle.
// Build after the last load: each join reads two entries, sums them and scans the work
//   list with the shared adder/comparator; ready stays low meanwhile.
// Reset: asynchronous, active low; tables are not cleared, symbol_count resets to 1.
// ----------------------------------------------------------------------------
// Huffman tree build and decode unit
// Top level: sequencer with shared adder/comparator plus node store.
// ----------------------------------------------------------------------------
module huffman_tree_build_and_decode_unit #(
  parameter int MAX_SYMBOLS = htd_pkg::MAX_SYMBOLS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  htd_in_if.sink    in_i,
  htd_out_if.source out_o,
  htd_cfg_if.sink   cfg_i
);

  localparam int IW = $clog2(2 * MAX_SYMBOLS);
  localparam int LW = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;
  localparam int EW = IW + htd_pkg::WEIGHT_W;
  localparam int NW = 2 * IW + 1;

  htd_pkg::mem_ctl_t         ctl;
  logic [LW-1:0]             wl_waddr;
  logic [LW-1:0]             wl_raddr;
  logic [EW-1:0]             wl_wdata;
  logic [EW-1:0]             wl_rdata;
  logic [IW-1:0]             node_waddr;
  logic [IW-1:0]             node_raddr;
  logic [NW-1:0]             node_wdata;
  logic [NW-1:0]             node_rdata;
  logic [LW-1:0]             sym_waddr;
  logic [LW-1:0]             sym_raddr;
  logic [htd_pkg::SYM_W-1:0] sym_wdata;
  logic [htd_pkg::SYM_W-1:0] sym_rdata;

  htd_ctrl #(
    .MAX_SYMBOLS (MAX_SYMBOLS)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .out_o        (out_o),
    .cfg_i        (cfg_i),
    .ctl_o        (ctl),
    .wl_waddr_o   (wl_waddr),
    .wl_raddr_o   (wl_raddr),
    .wl_wdata_o   (wl_wdata),
    .wl_rdata_i   (wl_rdata),
    .node_waddr_o (node_waddr),
    .node_raddr_o (node_raddr),
    .node_wdata_o (node_wdata),
    .node_rdata_i (node_rdata),
    .sym_waddr_o  (sym_waddr),
    .sym_raddr_o  (sym_raddr),
    .sym_wdata_o  (sym_wdata),
    .sym_rdata_i  (sym_rdata)
  );

  htd_store #(
    .MAX_SYMBOLS (MAX_SYMBOLS)
  ) u_store (
    .clk_i        (clk_i),
    .ctl_i        (ctl),
    .wl_waddr_i   (wl_waddr),
    .wl_raddr_i   (wl_raddr),
    .wl_wdata_i   (wl_wdata),
    .wl_rdata_o   (wl_rdata),
    .node_waddr_i (node_waddr),
    .node_raddr_i (node_raddr),
    .node_wdata_i (node_wdata),
    .node_rdata_o (node_rdata),
    .sym_waddr_i  (sym_waddr),
    .sym_raddr_i  (sym_raddr),
    .sym_wdata_i  (sym_wdata),
    .sym_rdata_o  (sym_rdata)
  );

endmodule

FILE: test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Huffman tree build and decode unit: self-checking testbench
// Loads leaf sets of many sizes, lets the unit build its tree, walks it with
// random code bits and checks every decoded symbol and status against an
// in-bench model of the node table, the ordered join list and the walk, or fixed values.
// ----------------------------------------------------------------------------
module testbench;
  import htd_pkg::*;

  localparam int NSYM        = MAX_SYMBOLS_DEF;
  localparam int NODES       = 2 * NSYM;
  localparam int NO_CHILD    = NODES;
  localparam int ITEM_TARGET = 1100;
  localparam int QUIET_LIMIT = 200000;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam logic [WEIGHT_IN_W-1:0] WEIGHT_MAX = '1;

  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    status_e          status;
  } decode_t;

  localparam decode_t NO_RESULT = '{symbol: '0, status: ST_OK};

  typedef struct {
    bit                     is_cfg;
    logic [CFG_W-1:0]       cfg_val;
    logic [OP_W-1:0]        op;
    logic [SYM_W-1:0]       symbol;
    logic [WEIGHT_IN_W-1:0] weight;
    logic                   code_bit;
    bit                     fixed;
    decode_t                fixed_res;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;

  htd_in_if  in_ch ();
  htd_out_if out_ch ();
  htd_cfg_if cfg_ch ();

  huffman_tree_build_and_decode_unit DUT (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_ch),
    .out_o (out_ch),
    .cfg_i (cfg_ch)
  );

  always #1 clk = ~clk;

  // tree model: leaves at 0..n-1, joined nodes after them
  logic [8:0]          tree_left   [NODES];
  logic [8:0]          tree_right  [NODES];
  logic [SYM_W-1:0]    tree_symbol [NODES];
  logic [WEIGHT_W-1:0] tree_weight [NODES];
  logic [8:0]          join_order  [NSYM];
  int unsigned count_reg  = 1;
  int unsigned leaves_n   = 0;
  int unsigned nodes_n    = 0;
  int unsigned root_node  = 0;
  int unsigned walk_node  = 0;
  bit          tree_built = 1'b0;
  int unsigned build_tail = 0;   // cycles a build just started may still take

  decode_t     expected_decodes [$];
  stim_row_t   directed_rows [$];
  decode_t     want;
  int unsigned items_done   = 0;
  int unsigned results_seen = 0;
  int unsigned builds_done  = 0;
  int unsigned cfg_writes   = 0;
  int unsigned mismatches   = 0;
  int unsigned big_trees    = 0;
  int unsigned quiet_cycles = 0;
  int          idle_pct     = 0;
  int          stall_pct    = 0;

  function automatic void flag_error(string msg);
    if (mismatches < 10) $display("MISMATCH @%0t: %s", $time, msg);
    mismatches++;
  endfunction

  function automatic void build_model_tree(int unsigned n);
    int unsigned j, idx, scanned;
    logic [8:0] a, b;
    logic [WEIGHT_W-1:0] w;
    scanned = 0;
    nodes_n = n;
    if (n <= 1) begin
      // lone leaf hangs left of a root with no right child
      tree_left[1]   = '0;
      tree_right[1]  = NO_CHILD;
      tree_symbol[1] = '0;
      tree_weight[1] = tree_weight[0];
      nodes_n        = 2;
      root_node      = 1;
    end else begin
      for (int unsigned i = 1; i < n; i++) begin
        a = join_order[i-1];
        b = join_order[i];
        idx = nodes_n;
        nodes_n++;
        tree_left[idx]   = a;
        tree_right[idx]  = b;
        tree_symbol[idx] = '0;
        w = tree_weight[a] + tree_weight[b];
        tree_weight[idx] = w;
        // new node goes behind every entry of equal or smaller weight
        j = i + 1;
        while (j < n && !(w < tree_weight[join_order[j]])) begin
          join_order[j-1] = join_order[j];
          j++;
          scanned++;
        end
        if (j < n) scanned++;
        join_order[j-1] = idx;
      end
      root_node = join_order[n-1];
    end
    tree_built = 1'b1;
    walk_node  = root_node;
    builds_done++;
    build_tail = 4 * n + 2 * scanned + 8;
  endfunction

  function automatic void predict_item(input logic [OP_W-1:0] op,
                                       input logic [SYM_W-1:0] symbol,
                                       input logic [WEIGHT_IN_W-1:0] weight,
                                       input logic code_bit,
                                       output bit has_res, output decode_t res,
                                       output bit ignored);
    int unsigned target, pos, child;
    has_res = 1'b0;
    ignored = 1'b0;
    res     = NO_RESULT;
    case (op)
      OP_CLEAR: begin
        leaves_n   = 0;
        nodes_n    = 0;
        tree_built = 1'b0;
        root_node  = 0;
        walk_node  = 0;
      end
      OP_LOAD: begin
        if (tree_built || leaves_n >= NSYM) begin
          ignored = 1'b1;
        end else begin
          tree_left[leaves_n]   = NO_CHILD;
          tree_right[leaves_n]  = NO_CHILD;
          tree_symbol[leaves_n] = symbol;
          tree_weight[leaves_n] = weight;
          join_order[leaves_n]  = leaves_n;
          leaves_n++;
          nodes_n = leaves_n;
          target = (count_reg == 0) ? 1 : (count_reg > NSYM) ? NSYM : count_reg;
          if (leaves_n >= target) build_model_tree(leaves_n);
        end
      end
      OP_DECODE: begin
        has_res = 1'b1;
        if (!tree_built) begin
          res.status = ST_NOT_BUILT;
        end else begin
          pos = walk_node;
          if (pos >= NODES) pos = root_node;
          child = code_bit ? tree_right[pos] : tree_left[pos];
          if (child >= NODES) begin
            walk_node  = root_node;
            res.status = ST_NO_BRANCH;
          end else if (child < leaves_n) begin
            walk_node  = root_node;
            res.symbol = tree_symbol[child];
          end else begin
            walk_node = child;
            has_res   = 1'b0;
          end
        end
      end
      default: ignored = 1'b1;
    endcase
  endfunction

  task automatic send_item(input logic [OP_W-1:0] op, input logic [SYM_W-1:0] symbol,
                           input logic [WEIGHT_IN_W-1:0] weight, input logic code_bit,
                           input bit fixed, input decode_t fixed_res);
    bit has_res, ignored;
    decode_t res;
    while ($urandom_range(0, 99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.op          <= op;
    in_ch.leaf_symbol <= symbol;
    in_ch.leaf_weight <= weight;
    in_ch.code_bit    <= code_bit;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    // input is held off during a build, so any transfer means it is done
    build_tail = 0;
    predict_item(op, symbol, weight, code_bit, has_res, res, ignored);
    if (has_res) expected_decodes.push_back(fixed ? fixed_res : res);
    if (!ignored) items_done++;
  endtask

  task automatic send_random(input logic [OP_W-1:0] op);
    send_item(op, $urandom_range(0, 255), $urandom_range(0, WEIGHT_MAX),
              $urandom_range(0, 1), 1'b0, NO_RESULT);
  endtask

  // quiesce: all results in, any build finished
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (expected_decodes.size() != 0) @(posedge clk);
    repeat (16 + 2 * build_tail) @(posedge clk);
  endtask

  task automatic write_count(input logic [CFG_W-1:0] value);
    cfg_ch.valid        <= 1'b1;
    cfg_ch.symbol_count <= value;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    cfg_ch.valid <= 1'b0;
    count_reg = value;
    cfg_writes++;
  endtask

  function automatic void add_row(bit is_cfg, logic [CFG_W-1:0] cfg_val,
                                  logic [OP_W-1:0] op, logic [SYM_W-1:0] symbol,
                                  logic [WEIGHT_IN_W-1:0] weight, logic code_bit,
                                  bit fixed, decode_t fixed_res);
    stim_row_t row;
    row.is_cfg    = is_cfg;
    row.cfg_val   = cfg_val;
    row.op        = op;
    row.symbol    = symbol;
    row.weight    = weight;
    row.code_bit  = code_bit;
    row.fixed     = fixed;
    row.fixed_res = fixed_res;
    directed_rows.push_back(row);
  endfunction

  task automatic decode_run(input int unsigned nbits);
    int r;
    for (int unsigned i = 0; i < nbits; i++) begin
      r = $urandom_range(0, 99);
      if (r < 3) send_random(OP_UNUSED);
      else if (r < 6) send_random(OP_LOAD);
      else if (r < 7) send_random(OP_CLEAR);
      else send_random(OP_DECODE);
    end
  endtask

  task automatic random_phase();
    int unsigned n, low_at, nbits, r;
    logic [CFG_W-1:0] cfg_v;
    logic [31:0] w;
    bit sorted;
    r = $urandom_range(0, 99);
    if (tree_built && r < 10) begin
      // rewrite the count on a built tree, the tree stays
      settle();
      write_count($urandom_range(0, 255));
      decode_run($urandom_range(10, 40));
      return;
    end
    r = $urandom_range(0, 99);
    if (r < 3 && big_trees < 2) begin
      n = NSYM;
      big_trees++;
    end else if (r < 10) begin
      n = 1;
    end else begin
      n = $urandom_range(2, 16);
    end
    cfg_v = n;
    if (n == 1 && $urandom_range(0, 1)) cfg_v = 0;
    if (n == NSYM && $urandom_range(0, 1)) cfg_v = $urandom_range(NSYM + 1, 255);
    low_at = (n > 2 && $urandom_range(0, 99) < 15) ? $urandom_range(1, n - 2) : 0;
    settle();
    write_count(cfg_v);
    send_random(OP_CLEAR);
    sorted = $urandom_range(0, 99) < 85;
    w = $urandom_range(0, WEIGHT_MAX) >> $urandom_range(0, 24);
    for (int unsigned k = 0; k < n; k++) begin
      if (low_at != 0 && k == low_at) begin
        // count lowered mid-load: next load triggers the build
        settle();
        write_count($urandom_range(1, k));
      end
      if ($urandom_range(0, 99) < 8)
        send_random($urandom_range(0, 1) ? OP_DECODE : OP_UNUSED);
      if (sorted) begin
        r = $urandom_range(0, 99);
        if (r < 60) w = w + $urandom_range(0, 255);
        else if (r < 90) w = w + $urandom_range(0, 65535);
        else w = w + $urandom_range(0, WEIGHT_MAX);
        if (w > WEIGHT_MAX) w = WEIGHT_MAX;
      end else begin
        w = $urandom_range(0, WEIGHT_MAX);
      end
      send_item(OP_LOAD, ($urandom_range(0, 99) < 3) ? 0 : $urandom_range(1, 255),
                w[WEIGHT_IN_W-1:0], $urandom_range(0, 1), 1'b0, NO_RESULT);
    end
    nbits = ((n >= 64) ? 150 : 6 * n + 8) + $urandom_range(0, 10);
    decode_run(nbits);
  endtask

  // result side: random back-pressure
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      results_seen++;
      if (expected_decodes.size() == 0) begin
        flag_error($sformatf("unexpected result sym=%0h status=%0d",
                             out_ch.decoded_symbol, out_ch.status));
      end else begin
        want = expected_decodes.pop_front();
        if (out_ch.decoded_symbol !== want.symbol || out_ch.status !== want.status)
          flag_error($sformatf("sym exp %0h got %0h, status exp %0d got %0d",
                               want.symbol, out_ch.decoded_symbol, want.status,
                               out_ch.status));
      end
    end
  end

  // watchdog on transfers of any kind
  always @(posedge clk) begin
    if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
        (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) ||
        (cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", QUIET_LIMIT);
      $display("testbench NOT OK");
      $finish;
    end
  end

  initial begin
    rst_n               <= 1'b0;
    in_ch.valid         <= 1'b0;
    in_ch.op            <= OP_CLEAR;
    in_ch.leaf_symbol   <= '0;
    in_ch.leaf_weight   <= '0;
    in_ch.code_bit      <= 1'b0;
    cfg_ch.valid        <= 1'b0;
    cfg_ch.symbol_count <= 8'd1;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // count is 1 out of reset
    add_row(0, 0, OP_DECODE, 0, 0, 0, 1, '{symbol: 8'h00, status: ST_NOT_BUILT});
    add_row(0, 0, OP_LOAD, 8'hFF, WEIGHT_MAX, 0, 0, NO_RESULT);
    add_row(0, 0, OP_DECODE, 0, 0, 0, 1, '{symbol: 8'hFF, status: ST_OK});
    add_row(0, 0, OP_DECODE, 0, 0, 1, 1, '{symbol: 8'h00, status: ST_NO_BRANCH});
    add_row(0, 0, OP_LOAD, 8'h55, 0, 1, 0, NO_RESULT);
    add_row(0, 0, OP_UNUSED, 8'hAA, WEIGHT_MAX, 1, 0, NO_RESULT);
    add_row(0, 0, OP_DECODE, 0, 0, 0, 1, '{symbol: 8'hFF, status: ST_OK});
    add_row(0, 0, OP_CLEAR, 0, 0, 0, 0, NO_RESULT);
    add_row(0, 0, OP_DECODE, 0, 0, 1, 1, '{symbol: 8'h00, status: ST_NOT_BUILT});
    add_row(1, 8'd3, 0, 0, 0, 0, 0, NO_RESULT);
    add_row(0, 0, OP_LOAD, 8'h01, 0, 0, 0, NO_RESULT);
    add_row(0, 0, OP_DECODE, 0, 0, 1, 1, '{symbol: 8'h00, status: ST_NOT_BUILT});
    add_row(0, 0, OP_LOAD, 8'h00, 0, 0, 0, NO_RESULT);
    add_row(0, 0, OP_LOAD, 8'h80, 24'd5, 0, 0, NO_RESULT);
    add_row(0, 0, OP_DECODE, 0, 0, 1, 0, NO_RESULT);
    add_row(0, 0, OP_DECODE, 0, 0, 0, 0, NO_RESULT);
    add_row(0, 0, OP_DECODE, 0, 0, 1, 0, NO_RESULT);
    // count of zero written over a built tree
    add_row(1, 8'd0, 0, 0, 0, 0, 0, NO_RESULT);
    add_row(0, 0, OP_DECODE, 0, 0, 0, 0, NO_RESULT);
    add_row(0, 0, OP_CLEAR, 8'hFF, WEIGHT_MAX, 1, 0, NO_RESULT);
    add_row(0, 0, OP_LOAD, 8'hAA, 24'h123456, 0, 0, NO_RESULT);
    add_row(0, 0, OP_DECODE, 0, 0, 1, 1, '{symbol: 8'h00, status: ST_NO_BRANCH});
    // oversized count, then lowered mid-load
    add_row(1, 8'd255, 0, 0, 0, 0, 0, NO_RESULT);
    add_row(0, 0, OP_CLEAR, 0, 0, 0, 0, NO_RESULT);
    add_row(0, 0, OP_LOAD, 8'h11, 24'd1, 0, 0, NO_RESULT);
    add_row(0, 0, OP_LOAD, 8'h22, 24'd2, 0, 0, NO_RESULT);
    add_row(0, 0, OP_LOAD, 8'h33, WEIGHT_MAX, 0, 0, NO_RESULT);
    add_row(1, 8'd2, 0, 0, 0, 0, 0, NO_RESULT);
    add_row(0, 0, OP_LOAD, 8'h44, WEIGHT_MAX, 0, 0, NO_RESULT);
    add_row(0, 0, OP_DECODE, 0, 0, 1, 0, NO_RESULT);
    add_row(0, 0, OP_DECODE, 0, 0, 0, 0, NO_RESULT);

    foreach (directed_rows[k]) begin
      if (directed_rows[k].is_cfg) begin
        settle();
        write_count(directed_rows[k].cfg_val);
      end else begin
        send_item(directed_rows[k].op, directed_rows[k].symbol, directed_rows[k].weight,
                  directed_rows[k].code_bit, directed_rows[k].fixed,
                  directed_rows[k].fixed_res);
      end
    end

    while (items_done < ITEM_TARGET) begin
      if (items_done < 400) begin
        idle_pct  = 18;
        stall_pct = 83;
      end else if (items_done < 750) begin
        idle_pct  = 83;
        stall_pct = 18;
      end else begin
        idle_pct  = 0;
        stall_pct = 0;
      end
      random_phase();
    end
    settle();

    $display("ran %0d items with %0d count writes and %0d tree builds (%0d full size);",
             items_done, cfg_writes, builds_done, big_trees);
    $display("checked %0d decode results, %0d mismatches", results_seen, mismatches);
    if (mismatches == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/htd_pkg.sv
hw/rtl/htd_if.sv
hw/rtl/htd_store.sv
hw/rtl/htd_ctrl.sv
hw/rtl/huffman_tree_build_and_decode_unit.sv
test/testbench.sv
